// ----- design/bsd_pkg.sv -----
// Shared types, status codes and character decode functions for the base64 stream decoder.
package bsd_pkg;

    localparam int unsigned DigitW = 6;
    localparam int unsigned ByteW  = 8;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_PAD  = 3'd1,
        ST_BAD_CHAR = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             byte_valid;
        logic             finished;
        status_t          status;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [DigitW-1:0] value;
    } digit_t;

    localparam logic [7:0] CharPad   = 8'h3d;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharCr    = 8'h0d;
    localparam logic [7:0] CharLf    = 8'h0a;
    localparam logic [7:0] CharPlus  = 8'h2b;
    localparam logic [7:0] CharSlash = 8'h2f;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpZ   = 8'h5a;
    localparam logic [7:0] CharLoA   = 8'h61;
    localparam logic [7:0] CharLoZ   = 8'h7a;
    localparam logic [7:0] Char0     = 8'h30;
    localparam logic [7:0] Char9     = 8'h39;

    localparam logic [7:0] OffsetLower = 8'd26;
    localparam logic [7:0] OffsetDigit = 8'd52;
    localparam logic [DigitW-1:0] DigitPlus  = 6'd62;
    localparam logic [DigitW-1:0] DigitSlash = 6'd63;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CharSpace) || (c == CharTab) || (c == CharCr) || (c == CharLf);
    endfunction

    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t     d;
        logic [7:0] t;
        d = '0;
        t = '0;
        if (c >= CharUpA && c <= CharUpZ)
        begin
            t = c - CharUpA;
            d.valid = 1'b1;
        end
        else if (c >= CharLoA && c <= CharLoZ)
        begin
            t = c - CharLoA + OffsetLower;
            d.valid = 1'b1;
        end
        else if (c >= Char0 && c <= Char9)
        begin
            t = c - Char0 + OffsetDigit;
            d.valid = 1'b1;
        end
        d.value = t[DigitW-1:0];
        if (c == CharPlus)
        begin
            d.valid = 1'b1;
            d.value = DigitPlus;
        end
        else if (c == CharSlash)
        begin
            d.valid = 1'b1;
            d.value = DigitSlash;
        end
        return d;
    endfunction

endpackage

// ----- design/base64_stream_decoder.sv -----
// Top level of the base64 stream decoder: input register, decode core and result register.
// Takes one base64 character per transaction and returns exactly one result per
// transaction, in order. A new character is accepted every cycle while results are
// taken; each item passes through the input register, then the result register, and the
// decode state is updated as an item moves from the input register into the result
// register. tready on the input follows tready on the output through the single input
// register stage. After the end-of-text transaction all decode state returns to its
// reset value.
module base64_stream_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,
    input  logic       s_axis_tuser,   // [0] has_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast,
    output logic [3:0] m_axis_tuser    // [0] byte_valid, [3:1] status
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_char_reg, in_char_next;
    logic             in_last_reg, in_last_next;
    logic             in_has_reg, in_has_next;
    logic             out_valid_reg, out_valid_next;
    bsd_pkg::result_t out_reg, out_next;
    bsd_pkg::result_t core_result;
    logic             advance;
    logic             s_fire;

    bsd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .has_char    (in_has_reg),
        .char_code   (in_char_reg),
        .end_of_text (in_last_reg),
        .result      (core_result)
    );

    always_comb
    begin
        advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready = !in_valid_reg || advance;
        s_fire        = s_axis_tvalid && s_axis_tready;

        in_valid_next = s_fire || (in_valid_reg && !advance);
        in_char_next  = s_fire ? s_axis_tdata : in_char_reg;
        in_last_next  = s_fire ? s_axis_tlast : in_last_reg;
        in_has_next   = s_fire ? s_axis_tuser : in_has_reg;

        out_valid_next = advance || (out_valid_reg && !m_axis_tready);
        out_next       = advance ? core_result : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_char_reg <= in_char_next;
        in_last_reg <= in_last_next;
        in_has_reg  <= in_has_next;
        out_reg     <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.data_byte;
    assign m_axis_tlast  = out_reg.finished;
    assign m_axis_tuser  = {out_reg.status, out_reg.byte_valid};

    // a byte is only produced while no error is pending
    a_byte_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_valid && !out_reg.finished
        |-> out_reg.status == bsd_pkg::ST_OK)
        else $error("byte emitted with error status");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.byte_valid |-> out_reg.data_byte == 8'd0)
        else $error("data byte nonzero without byte_valid");

endmodule

// ----- design/bsd_core.sv -----
// Decoder state and per-character update logic; produces one result per transaction.
module bsd_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             has_char,
    input  logic [7:0]       char_code,
    input  logic             end_of_text,
    output bsd_pkg::result_t result
);

    logic [5:0]       leftover_reg, leftover_next;
    logic [2:0]       bit_count_reg, bit_count_next;
    logic             pad_reg, pad_next;
    bsd_pkg::status_t err_reg, err_next;
    logic             any_byte_reg, any_byte_next;

    bsd_pkg::digit_t  dig;
    logic [11:0]      acc;
    logic [3:0]       n_sum;
    logic [2:0]       n_new;
    logic [11:0]      shifted;
    logic [5:0]       upd_leftover;
    logic [2:0]       upd_count;
    logic             upd_pad;
    bsd_pkg::status_t upd_err;
    logic             upd_any;
    logic [7:0]       byte_val;
    logic             byte_ok;
    bsd_pkg::status_t fin_status;

    always_comb
    begin
        dig          = bsd_pkg::digit_of(char_code);
        acc          = {leftover_reg, dig.value};
        n_sum        = {1'b0, bit_count_reg} + 4'd6;
        n_new        = n_sum[3] ? n_sum[2:0] : n_sum[2:0];
        shifted      = acc >> n_new;
        upd_leftover = leftover_reg;
        upd_count    = bit_count_reg;
        upd_pad      = pad_reg;
        upd_err      = err_reg;
        upd_any      = any_byte_reg;
        byte_val     = '0;
        byte_ok      = 1'b0;

        if (has_char && err_reg == bsd_pkg::ST_OK)
        begin
            if (char_code == bsd_pkg::CharPad)
            begin
                upd_pad = 1'b1;
            end
            else if (bsd_pkg::is_space(char_code))
            begin
                upd_pad = pad_reg;
            end
            else if (pad_reg)
            begin
                upd_err = bsd_pkg::ST_BAD_PAD;
            end
            else if (!dig.valid)
            begin
                upd_err = bsd_pkg::ST_BAD_CHAR;
            end
            else
            begin
                if (n_sum[3])
                begin
                    byte_val = shifted[7:0];
                    byte_ok  = 1'b1;
                    upd_any  = 1'b1;
                end
                upd_count = n_new;
                for (int i = 0; i < 6; i++)
                begin
                    upd_leftover[i] = acc[i] && (3'(i) < n_new);
                end
            end
        end

        fin_status = upd_err;
        if (upd_err == bsd_pkg::ST_OK)
        begin
            if (upd_count >= 3'd6 || (upd_count != 3'd0 && upd_leftover != 6'd0))
            begin
                fin_status = bsd_pkg::ST_TRUNC;
            end
            else if (!upd_any)
            begin
                fin_status = bsd_pkg::ST_EMPTY;
            end
        end

        result.data_byte  = byte_val;
        result.byte_valid = byte_ok;
        result.finished   = end_of_text;
        result.status     = end_of_text ? fin_status : upd_err;

        leftover_next  = leftover_reg;
        bit_count_next = bit_count_reg;
        pad_next       = pad_reg;
        err_next       = err_reg;
        any_byte_next  = any_byte_reg;
        if (fire)
        begin
            if (end_of_text)
            begin
                leftover_next  = '0;
                bit_count_next = '0;
                pad_next       = 1'b0;
                err_next       = bsd_pkg::ST_OK;
                any_byte_next  = 1'b0;
            end
            else
            begin
                leftover_next  = upd_leftover;
                bit_count_next = upd_count;
                pad_next       = upd_pad;
                err_next       = upd_err;
                any_byte_next  = upd_any;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_reg  <= '0;
            bit_count_reg <= '0;
            pad_reg       <= 1'b0;
            err_reg       <= bsd_pkg::ST_OK;
            any_byte_reg  <= 1'b0;
        end
        else
        begin
            leftover_reg  <= leftover_next;
            bit_count_reg <= bit_count_next;
            pad_reg       <= pad_next;
            err_reg       <= err_next;
            any_byte_reg  <= any_byte_next;
        end
    end

    // bit count only steps by six modulo eight from zero
    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg[0] == 1'b0)
        else $error("bit count is odd");

    a_leftover_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (leftover_reg >> bit_count_reg) == 6'd0)
        else $error("leftover bits above bit count");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_of_text |=> bit_count_reg == 3'd0 && err_reg == bsd_pkg::ST_OK
                                && !pad_reg && !any_byte_reg)
        else $error("state not cleared after end of text");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != bsd_pkg::ST_OK && !(fire && end_of_text) |=> err_reg == $past(err_reg))
        else $error("error code changed before end of text");

endmodule

// ----- tb/tb_base64_stream_decoder.sv -----
// Testbench for base64_stream_decoder: directed table and random base64 text against a predictor.
module tb_base64_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       has_char;
        logic [7:0] code;
        logic       last;
    } text_item_t;

    typedef struct packed {
        text_item_t       item;
        logic             typed;
        bsd_pkg::result_t want;
    } dir_row_t;

    localparam bsd_pkg::result_t RES_NONE = '{8'h00, 1'b0, 1'b0, bsd_pkg::ST_OK};
    localparam int      NUM_DIRECTED = 26;
    localparam int      PHASE_ITEMS  = 160;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       s_axis_tuser = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [3:0] m_axis_tuser;

    int               idle_pct = 0;
    int               stall_pct = 0;
    int               mismatch_count = 0;
    bsd_pkg::result_t expected_results[$];
    text_item_t       text_q[$];
    dir_row_t         directed_rows [NUM_DIRECTED];

    // decoder state as predicted
    logic [6:0]       carry_bits = '0;
    logic [2:0]       carry_cnt = '0;
    logic             pad_mark = 1'b0;
    bsd_pkg::status_t sticky_err = bsd_pkg::ST_OK;
    logic             emitted_any = 1'b0;

    base64_stream_decoder i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bsd_pkg::result_t decode_step(input text_item_t it);
        bsd_pkg::result_t r;
        logic [5:0]       sextet;
        logic [11:0]      acc;
        logic [3:0]       n;
        logic             known;
        logic             is_ws;
        r = RES_NONE;
        if (it.has_char && sticky_err == bsd_pkg::ST_OK)
        begin
            known = 1'b1;
            sextet = '0;
            if (it.code >= bsd_pkg::CharUpA && it.code <= bsd_pkg::CharUpZ)
                sextet = 6'(it.code - bsd_pkg::CharUpA);
            else if (it.code >= bsd_pkg::CharLoA && it.code <= bsd_pkg::CharLoZ)
                sextet = 6'(it.code - bsd_pkg::CharLoA + bsd_pkg::OffsetLower);
            else if (it.code >= bsd_pkg::Char0 && it.code <= bsd_pkg::Char9)
                sextet = 6'(it.code - bsd_pkg::Char0 + bsd_pkg::OffsetDigit);
            else if (it.code == bsd_pkg::CharPlus)
                sextet = bsd_pkg::DigitPlus;
            else if (it.code == bsd_pkg::CharSlash)
                sextet = bsd_pkg::DigitSlash;
            else
                known = 1'b0;
            is_ws = (it.code == bsd_pkg::CharSpace) || (it.code == bsd_pkg::CharTab) ||
                    (it.code == bsd_pkg::CharCr) || (it.code == bsd_pkg::CharLf);
            if (it.code == bsd_pkg::CharPad)
                pad_mark = 1'b1;
            else if (!is_ws)
            begin
                if (pad_mark)
                    sticky_err = bsd_pkg::ST_BAD_PAD;
                else if (!known)
                    sticky_err = bsd_pkg::ST_BAD_CHAR;
                else
                begin
                    acc = {carry_bits[5:0], sextet};
                    n = {1'b0, carry_cnt} + 4'd6;
                    if (n >= 4'd8)
                    begin
                        n = n - 4'd8;
                        r.data_byte = 8'(acc >> n);
                        r.byte_valid = 1'b1;
                        emitted_any = 1'b1;
                    end
                    carry_cnt = n[2:0];
                    carry_bits = 7'(acc & ((12'd1 << n) - 12'd1));
                end
            end
        end
        r.status = sticky_err;
        if (it.last)
        begin
            r.finished = 1'b1;
            if (sticky_err == bsd_pkg::ST_OK)
            begin
                if (carry_cnt >= 3'd6 || (carry_cnt != 3'd0 && carry_bits != 7'd0))
                    r.status = bsd_pkg::ST_TRUNC;
                else if (!emitted_any)
                    r.status = bsd_pkg::ST_EMPTY;
            end
            carry_bits = '0;
            carry_cnt = '0;
            pad_mark = 1'b0;
            sticky_err = bsd_pkg::ST_OK;
            emitted_any = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return bsd_pkg::CharUpA + 8'(v);
        else if (v < 6'd52)
            return bsd_pkg::CharLoA + 8'(v) - bsd_pkg::OffsetLower;
        else if (v < bsd_pkg::DigitPlus)
            return bsd_pkg::Char0 + 8'(v) - bsd_pkg::OffsetDigit;
        else if (v == bsd_pkg::DigitPlus)
            return bsd_pkg::CharPlus;
        return bsd_pkg::CharSlash;
    endfunction

    function automatic logic [7:0] random_byte();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // append one transaction to the pending text
    function automatic void queue_text(input text_item_t it);
        text_q.insert(text_q.size(), it);
    endfunction

    // queue one character, sometimes preceded by whitespace or a bare transaction
    function automatic void push_text(input logic [7:0] code);
        text_item_t filler;
        if ($urandom_range(7) == 0)
        begin
            filler.has_char = 1'b1;
            filler.last = 1'b0;
            case ($urandom_range(3))
                0: filler.code = bsd_pkg::CharSpace;
                1: filler.code = bsd_pkg::CharTab;
                2: filler.code = bsd_pkg::CharCr;
                default: filler.code = bsd_pkg::CharLf;
            endcase
            queue_text(filler);
        end
        if ($urandom_range(19) == 0)
            queue_text(text_item_t'{1'b0, random_byte(), 1'b0});
        queue_text(text_item_t'{1'b1, code, 1'b0});
    endfunction

    task automatic send_item(input text_item_t it, input logic typed,
                             input bsd_pkg::result_t want);
        bsd_pkg::result_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.has_char;
        s_axis_tdata <= it.code;
        s_axis_tlast <= it.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = decode_step(it);
        expected_results.insert(expected_results.size(), typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic send_random_sequence(output int count);
        logic [7:0]  b[3];
        logic [23:0] group;
        int          kind;
        int          nbytes;
        int          rem;
        int          pos;
        logic        use_pad;
        kind = $urandom_range(9);
        if (kind <= 7)
        begin
            nbytes = ($urandom_range(15) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            use_pad = 1'($urandom_range(1));
            for (int i = 0; i < nbytes; i += 3)
            begin
                rem = (nbytes - i < 3) ? nbytes - i : 3;
                for (int k = 0; k < 3; k++)
                    b[k] = (k < rem) ? random_byte() : 8'h00;
                group = {b[0], b[1], b[2]};
                for (int k = 0; k <= rem; k++)
                    push_text(sextet_char(group[23 - 6 * k -: 6]));
                if (rem < 3 && use_pad)
                    for (int k = rem; k < 3; k++)
                        push_text(bsd_pkg::CharPad);
            end
            if (kind == 7 && text_q.size() > 0)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        pos = $urandom_range(text_q.size() - 1);
                        text_q[pos].code = random_byte();
                    end
                    1: void'(text_q.pop_back());
                    default:
                    begin
                        push_text(bsd_pkg::CharPad);
                        push_text(sextet_char(6'($urandom_range(63))));
                    end
                endcase
            end
        end
        else
        begin
            nbytes = $urandom_range(1, 8);
            for (int i = 0; i < nbytes; i++)
                queue_text(text_item_t'{($urandom_range(4) != 0), random_byte(), 1'b0});
        end
        if (text_q.size() == 0 || $urandom_range(3) == 0)
            queue_text(text_item_t'{1'b0, random_byte(), 1'b1});
        else
            text_q[text_q.size() - 1].last = 1'b1;
        count = text_q.size();
        foreach (text_q[i])
            send_item(text_q[i], 1'b0, RES_NONE);
        text_q.delete();
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : result_check
        bsd_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, actual data %0h user %0h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("data_byte", want.data_byte, m_axis_tdata);
                check_field("byte_valid", 8'(want.byte_valid), 8'(m_axis_tuser[0]));
                check_field("finished", 8'(want.finished), 8'(m_axis_tlast));
                check_field("status", 8'(want.status), 8'(m_axis_tuser[3:1]));
            end
        end
    end

    initial
    begin
        #(2_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int sent;
        int phase_items;
        directed_rows = '{
            '{'{1'b0, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, bsd_pkg::ST_OK}},
            '{'{1'b0, 8'hff, 1'b0}, 1'b0, RES_NONE},
            '{'{1'b0, 8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, bsd_pkg::ST_EMPTY}},
            '{'{1'b1, "/", 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, "/", 1'b0}, 1'b1, '{8'hff, 1'b1, 1'b0, bsd_pkg::ST_OK}},
            '{'{1'b1, "/", 1'b0}, 1'b1, '{8'hff, 1'b1, 1'b0, bsd_pkg::ST_OK}},
            '{'{1'b1, "/", 1'b1}, 1'b1, '{8'hff, 1'b1, 1'b1, bsd_pkg::ST_OK}},
            '{'{1'b1, "T", 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, bsd_pkg::CharSpace, 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, "Q", 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, bsd_pkg::CharTab, 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, bsd_pkg::CharPad, 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, bsd_pkg::CharCr, 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, bsd_pkg::CharPad, 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, bsd_pkg::CharLf, 1'b1}, 1'b0, RES_NONE},
            '{'{1'b1, "A", 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, "A", 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, bsd_pkg::ST_OK}},
            '{'{1'b1, bsd_pkg::CharPad, 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, "B", 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, bsd_pkg::ST_BAD_PAD}},
            '{'{1'b1, "A", 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, bsd_pkg::ST_BAD_PAD}},
            '{'{1'b0, 8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, bsd_pkg::ST_BAD_PAD}},
            '{'{1'b1, 8'hff, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, bsd_pkg::ST_BAD_CHAR}},
            '{'{1'b1, "A", 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, bsd_pkg::ST_TRUNC}},
            '{'{1'b1, "A", 1'b0}, 1'b0, RES_NONE},
            '{'{1'b1, "B", 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, bsd_pkg::ST_TRUNC}},
            '{'{1'b1, bsd_pkg::CharPad, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, bsd_pkg::ST_EMPTY}}
        };
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                send_random_sequence(sent);
                phase_items += sent;
            end
            // hold off until the pipeline has drained
            s_axis_tvalid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end

        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
